// ===== design/sm83_pkg.sv =====
package sm83_pkg;

	localparam int FUNC_W   = 5;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 24;

	// flag positions in flags_in / flags_out
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	localparam logic [8:0] DAA_HI_LIMIT = 9'h09F;
	localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
	localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
	localparam logic [3:0] DAA_LO_LIMIT = 4'd9;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD   = 5'd0,
		FN_ADC   = 5'd1,
		FN_SUB   = 5'd2,
		FN_SBC   = 5'd3,
		FN_AND   = 5'd4,
		FN_XOR   = 5'd5,
		FN_OR    = 5'd6,
		FN_CP    = 5'd7,
		FN_INC   = 5'd8,
		FN_DEC   = 5'd9,
		FN_RLC   = 5'd10,
		FN_RRC   = 5'd11,
		FN_RL    = 5'd12,
		FN_RR    = 5'd13,
		FN_SLA   = 5'd14,
		FN_SRA   = 5'd15,
		FN_SWAP  = 5'd16,
		FN_SRL   = 5'd17,
		FN_BIT   = 5'd18,
		FN_RES   = 5'd19,
		FN_SET   = 5'd20,
		FN_DAA   = 5'd21,
		FN_CPL   = 5'd22,
		FN_SCF   = 5'd23,
		FN_CCF   = 5'd24,
		FN_RLCA  = 5'd25,
		FN_RRCA  = 5'd26,
		FN_RLA   = 5'd27,
		FN_RRA   = 5'd28,
		FN_ADD16 = 5'd29,
		FN_ADDSP = 5'd30
	} func_t;

endpackage

// ===== design/sm83_alu_with_flags.sv =====
// SM83 execution unit: each transaction carries one operation code in s_tuser
// and its operands in s_tdata, and returns the 16-bit result and the Z N H C
// flags on m_tdata. The datapath is three register stages (operand setup,
// arithmetic, flag assembly), and a result passes through all three
// registers before m_tvalid is raised. While m_tready is high one
// transaction per clock is sustained. Backpressure on m_tready holds
// only the stages that are full, so bubbles ahead of a stalled result still
// fill and s_tready stays high while any stage is free. Flags an operation
// does not touch pass through from the incoming flags.
module sm83_alu_with_flags (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// acc[7:0], operand[15:8], bit_index[18:16], wide_a[34:19],
	// wide_b[50:35], flags_in[54:51], zero pad[55]
	input  logic [sm83_pkg::S_DATA_W-1:0] s_tdata,
	// func[4:0]
	input  logic [sm83_pkg::FUNC_W-1:0]   s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// result[15:0], flags_out[19:16], zero pad[23:20]
	output logic [sm83_pkg::M_DATA_W-1:0] m_tdata
);
	import sm83_pkg::*;

	// stage advance chain
	logic adv1, adv2, adv3;
	logic vld_s1, vld_s2, vld_s3;

	assign adv3     = !vld_s3 || m_tready;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= s_tvalid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	// ---------------- stage 1: unpack and set up operands
	func_t       fn_in;
	logic [7:0]  acc_in, opnd_in;
	logic [2:0]  bidx_in;
	logic [15:0] wa_in, wb_in;
	logic [3:0]  flg_in;
	logic        sub_in, t_in;

	assign fn_in   = func_t'(s_tuser);
	assign acc_in  = s_tdata[7:0];
	assign opnd_in = s_tdata[15:8];
	assign bidx_in = s_tdata[18:16];
	assign wa_in   = s_tdata[34:19];
	assign wb_in   = s_tdata[50:35];
	assign flg_in  = s_tdata[54:51];

	always_comb begin
		sub_in = fn_in inside {FN_SUB, FN_SBC, FN_CP};
		t_in   = (fn_in inside {FN_ADC, FN_SBC}) ? flg_in[FLAG_C] : 1'b0;
	end

	func_t       fn_s1;
	logic [7:0]  acc_s1, opnd_s1, b_s1, rx_s1, mask_s1;
	logic [15:0] wa_s1, wb_s1;
	logic [3:0]  flg_s1;
	logic        cin_s1, sub_s1;

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			fn_s1   <= fn_in;
			acc_s1  <= acc_in;
			opnd_s1 <= opnd_in;
			// subtract as add of the complement with inverted borrow
			b_s1    <= sub_in ? ~opnd_in : opnd_in;
			cin_s1  <= sub_in ? ~t_in : t_in;
			sub_s1  <= sub_in;
			rx_s1   <= (fn_in inside {FN_RLCA, FN_RRCA, FN_RLA, FN_RRA}) ? acc_in : opnd_in;
			mask_s1 <= 8'b1 << bidx_in;
			wa_s1   <= wa_in;
			wb_s1   <= wb_in;
			flg_s1  <= flg_in;
		end
	end

	// ---------------- stage 2: arithmetic
	logic [8:0]  sum9, daa_x1;
	logic [4:0]  sum5, sp5;
	logic [8:0]  sp9;
	logic [16:0] w17;
	logic [12:0] w13;
	logic [15:0] sp16;
	logic        daa_lo, daa_hi, fc1;
	logic [7:0]  daa_add, daa_sub;
	logic [15:0] res_d;
	logic [7:0]  zsrc_d;
	logic        h_d, c_d;

	assign fc1  = flg_s1[FLAG_C];
	assign sum9 = {1'b0, acc_s1} + {1'b0, b_s1} + {8'b0, cin_s1};
	assign sum5 = {1'b0, acc_s1[3:0]} + {1'b0, b_s1[3:0]} + {4'b0, cin_s1};
	assign w17  = {1'b0, wa_s1} + {1'b0, wb_s1};
	assign w13  = {1'b0, wa_s1[11:0]} + {1'b0, wb_s1[11:0]};
	assign sp16 = wa_s1 + {{8{opnd_s1[7]}}, opnd_s1};
	assign sp5  = {1'b0, wa_s1[3:0]} + {1'b0, opnd_s1[3:0]};
	assign sp9  = {1'b0, wa_s1[7:0]} + {1'b0, opnd_s1};

	assign daa_lo  = flg_s1[FLAG_H] || (acc_s1[3:0] > DAA_LO_LIMIT);
	assign daa_x1  = {1'b0, acc_s1} + (daa_lo ? {1'b0, DAA_LO_ADJ} : 9'd0);
	assign daa_hi  = fc1 || (daa_x1 > DAA_HI_LIMIT);
	assign daa_add = daa_x1[7:0] + (daa_hi ? DAA_HI_ADJ : 8'd0);
	assign daa_sub = acc_s1 - (flg_s1[FLAG_H] ? DAA_LO_ADJ : 8'd0)
		- (fc1 ? DAA_HI_ADJ : 8'd0);

	always_comb begin
		res_d = {8'h00, acc_s1};
		h_d   = 1'b0;
		c_d   = 1'b0;
		case (fn_s1)
			FN_ADD, FN_ADC, FN_SUB, FN_SBC, FN_CP: begin
				res_d = {8'h00, sum9[7:0]};
				h_d   = sum5[4] ^ sub_s1;
				c_d   = sum9[8] ^ sub_s1;
			end
			FN_AND: res_d = {8'h00, acc_s1 & opnd_s1};
			FN_XOR: res_d = {8'h00, acc_s1 ^ opnd_s1};
			FN_OR:  res_d = {8'h00, acc_s1 | opnd_s1};
			FN_INC: begin
				res_d = {8'h00, opnd_s1 + 8'd1};
				h_d   = (opnd_s1[3:0] == 4'hF);
			end
			FN_DEC: begin
				res_d = {8'h00, opnd_s1 - 8'd1};
				h_d   = (opnd_s1[3:0] == 4'h0);
			end
			FN_RLC, FN_RLCA: begin
				res_d = {8'h00, rx_s1[6:0], rx_s1[7]};
				c_d   = rx_s1[7];
			end
			FN_RRC, FN_RRCA: begin
				res_d = {8'h00, rx_s1[0], rx_s1[7:1]};
				c_d   = rx_s1[0];
			end
			FN_RL, FN_RLA: begin
				res_d = {8'h00, rx_s1[6:0], fc1};
				c_d   = rx_s1[7];
			end
			FN_RR, FN_RRA: begin
				res_d = {8'h00, fc1, rx_s1[7:1]};
				c_d   = rx_s1[0];
			end
			FN_SLA: begin
				res_d = {8'h00, rx_s1[6:0], 1'b0};
				c_d   = rx_s1[7];
			end
			FN_SRA: begin
				res_d = {8'h00, rx_s1[7], rx_s1[7:1]};
				c_d   = rx_s1[0];
			end
			FN_SWAP: res_d = {8'h00, rx_s1[3:0], rx_s1[7:4]};
			FN_SRL: begin
				res_d = {8'h00, 1'b0, rx_s1[7:1]};
				c_d   = rx_s1[0];
			end
			FN_BIT: res_d = {8'h00, opnd_s1};
			FN_RES: res_d = {8'h00, opnd_s1 & ~mask_s1};
			FN_SET: res_d = {8'h00, opnd_s1 | mask_s1};
			FN_DAA: begin
				res_d = {8'h00, flg_s1[FLAG_N] ? daa_sub : daa_add};
				c_d   = flg_s1[FLAG_N] ? fc1 : daa_hi;
			end
			FN_CPL: res_d = {8'h00, ~acc_s1};
			FN_ADD16: begin
				res_d = w17[15:0];
				h_d   = w13[12];
				c_d   = w17[16];
			end
			FN_ADDSP: begin
				res_d = sp16;
				h_d   = sp5[4];
				c_d   = sp9[8];
			end
			default: res_d = {8'h00, acc_s1};
		endcase
		// compare keeps the accumulator but tests the difference
		zsrc_d = res_d[7:0];
		if (fn_s1 == FN_CP) begin
			res_d = {8'h00, acc_s1};
		end
		if (fn_s1 == FN_BIT) begin
			zsrc_d = {7'b0, |(opnd_s1 & mask_s1)};
		end
	end

	func_t       fn_s2;
	logic [15:0] res_s2;
	logic [7:0]  zsrc_s2;
	logic        h_s2, c_s2;
	logic [3:0]  flg_s2;

	always_ff @(posedge clk) begin
		if (adv2 && vld_s1) begin
			fn_s2   <= fn_s1;
			res_s2  <= res_d;
			zsrc_s2 <= zsrc_d;
			h_s2    <= h_d;
			c_s2    <= c_d;
			flg_s2  <= flg_s1;
		end
	end

	// ---------------- stage 3: flag assembly
	logic       z2, fz2, fn2, fc2;
	logic [3:0] nf_d;

	assign z2  = (zsrc_s2 == 8'h00);
	assign fz2 = flg_s2[FLAG_Z];
	assign fn2 = flg_s2[FLAG_N];
	assign fc2 = flg_s2[FLAG_C];

	// flag vector order: Z N H C
	always_comb begin
		case (fn_s2)
			FN_ADD, FN_ADC:         nf_d = {z2, 1'b0, h_s2, c_s2};
			FN_SUB, FN_SBC, FN_CP:  nf_d = {z2, 1'b1, h_s2, c_s2};
			FN_AND:                 nf_d = {z2, 1'b0, 1'b1, 1'b0};
			FN_XOR, FN_OR, FN_SWAP: nf_d = {z2, 1'b0, 1'b0, 1'b0};
			FN_INC:                 nf_d = {z2, 1'b0, h_s2, fc2};
			FN_DEC:                 nf_d = {z2, 1'b1, h_s2, fc2};
			FN_RLC, FN_RRC, FN_RL, FN_RR, FN_SLA, FN_SRA, FN_SRL:
				nf_d = {z2, 1'b0, 1'b0, c_s2};
			FN_RLCA, FN_RRCA, FN_RLA, FN_RRA:
				nf_d = {1'b0, 1'b0, 1'b0, c_s2};
			FN_BIT:                 nf_d = {z2, 1'b0, 1'b1, fc2};
			FN_DAA:                 nf_d = {z2, fn2, 1'b0, c_s2};
			FN_CPL:                 nf_d = {fz2, 1'b1, 1'b1, fc2};
			FN_SCF:                 nf_d = {fz2, 1'b0, 1'b0, 1'b1};
			FN_CCF:                 nf_d = {fz2, 1'b0, 1'b0, ~fc2};
			FN_ADD16:               nf_d = {fz2, 1'b0, h_s2, c_s2};
			FN_ADDSP:               nf_d = {1'b0, 1'b0, h_s2, c_s2};
			default:                nf_d = flg_s2;
		endcase
	end

	logic [15:0] res_s3;
	logic [3:0]  flags_s3;

	always_ff @(posedge clk) begin
		if (adv3 && vld_s2) begin
			res_s3   <= res_s2;
			flags_s3 <= nf_d;
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = {4'b0000, flags_s3, res_s3};

endmodule

// ===== design/sm83_chk.sv =====
module sm83_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [sm83_pkg::S_DATA_W-1:0] s_tdata,
	input logic [sm83_pkg::FUNC_W-1:0]   s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [sm83_pkg::M_DATA_W-1:0] m_tdata
);
	import sm83_pkg::*;

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// free output stage means every stage can advance
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled with a free pipeline");

	// an accepted transaction reaches the output when there is no backpressure
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("transaction did not reach the output in time");

	// pad bits above the flags stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:20] == '0)
		else $error("nonzero pad on output");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind sm83_alu_with_flags sm83_chk u_sm83_chk (.*);
